>>> rtl/brr_pkg.sv
package brr_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_DELIVER  = 3'd0,
    KIND_BUFFERED = 3'd1,
    KIND_OLD      = 3'd2,
    KIND_BEYOND   = 3'd3,
    KIND_REPORT   = 3'd4
  } kind_e;

  // position of a data frame against the expected number
  typedef enum logic [2:0] {
    CLS_EXP,
    CLS_OLD,
    CLS_NEW,
    CLS_DUP,
    CLS_FAR
  } cls_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_DATA,
    S_DRD,
    S_DEMIT,
    S_FRD,
    S_FEX,
    S_FCHK,
    S_SINIT,
    S_SCAN1,
    S_SCAN2,
    S_REPORT
  } state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic data_act;
    logic tag_rd;
    logic drain_emit;
    logic load_steps;
    logic flush_step;
    logic scan_init;
    logic scan1;
    logic scan2_init;
    logic scan2;
    logic report;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic req;
    logic req_adv;
    logic mod_done;
    logic next_full;
    logic head_full;
    logic steps_one;
    logic cnt_end;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/brr_ctrl.sv
module brr_ctrl
  import brr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          if (!sts_i.req) state_d = S_DATA;
          else if (sts_i.req_adv) state_d = S_FRD;
          else state_d = S_SINIT;
        end
      end
      S_DATA: begin
        if (sts_i.out_free) begin
          if (sts_i.cls == CLS_EXP && sts_i.next_full) state_d = S_DRD;
          else state_d = S_IDLE;
        end
      end
      S_DRD: state_d = S_DEMIT;
      S_DEMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.next_full) state_d = S_DRD;
          else if (sts_i.req) state_d = S_SINIT;
          else state_d = S_IDLE;
        end
      end
      S_FRD: state_d = S_FEX;
      S_FEX: begin
        if (!sts_i.head_full || sts_i.out_free) begin
          state_d = sts_i.steps_one ? S_FCHK : S_FRD;
        end
      end
      S_FCHK: state_d = sts_i.head_full ? S_DRD : S_SINIT;
      S_SINIT: state_d = S_SCAN1;
      S_SCAN1: begin
        if (sts_i.cnt_end) state_d = S_SCAN2;
      end
      S_SCAN2: begin
        if (sts_i.cnt_end) state_d = S_REPORT;
      end
      S_REPORT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_MOD: begin
        cmd_o.mod_step   = !sts_i.mod_done;
        cmd_o.load_steps = sts_i.mod_done && sts_i.req && sts_i.req_adv;
      end
      S_DATA:   cmd_o.data_act = sts_i.out_free;
      S_DRD:    cmd_o.tag_rd = 1'b1;
      S_DEMIT:  cmd_o.drain_emit = sts_i.out_free;
      S_FRD:    cmd_o.tag_rd = 1'b1;
      S_FEX:    cmd_o.flush_step = !sts_i.head_full || sts_i.out_free;
      S_FCHK:   cmd_o = '0;
      S_SINIT:  cmd_o.scan_init = 1'b1;
      S_SCAN1: begin
        cmd_o.scan1      = 1'b1;
        cmd_o.scan2_init = sts_i.cnt_end;
      end
      S_SCAN2:  cmd_o.scan2 = 1'b1;
      S_REPORT: cmd_o.report = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> rtl/brr_dp.sv
module brr_dp
  import brr_pkg::*;
#(
  parameter int W        = 64,
  parameter int SEQ_BITS = 12,
  parameter int TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mode_i,
  input  logic [SEQ_BITS-1:0] seq_num_i,
  input  logic [TAG_BITS-1:0] frame_tag_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [2:0]          kind_o,
  output logic [SEQ_BITS-1:0] out_seq_o,
  output logic [TAG_BITS-1:0] out_tag_o,
  output logic [W-1:0]        ack_bitmap_o,
  output logic                last_o
);

  localparam int IDXW = $clog2(W);
  localparam int CNTW = $clog2(W + 1);
  localparam int MODW = 2;
  // reciprocal of the window size, scaled so the quotient is off by at most one
  localparam int QSH  = SEQ_BITS + IDXW;
  localparam logic [SEQ_BITS:0] RECIP = (SEQ_BITS+1)'((64'd1 << QSH) / W);

  // session and window state
  logic                open_q, open_d;
  logic [SEQ_BITS-1:0] exp_q, exp_d;
  logic [IDXW-1:0]     head_q, head_d;
  logic [W-1:0]        full_q, full_d;
  logic [W-1:0]        mvld_q, mvld_d;
  // current request
  logic                mode_q, mode_d;
  logic [SEQ_BITS-1:0] seq_q, seq_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  // mark index computation
  logic [SEQ_BITS-1:0] quo_q, quo_d;
  logic [MODW-1:0]     mcnt_q, mcnt_d;
  logic [IDXW-1:0]     rem_q, rem_d;
  // flush and scan
  logic [CNTW-1:0]     steps_q, steps_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic                pv_q, pv_d;
  logic [IDXW-1:0]     pidx_q, pidx_d;
  logic [SEQ_BITS-1:0] min_q, min_d;
  logic [W-1:0]        bmp_q, bmp_d;
  // output register
  logic                ov_q, ov_d;
  logic [2:0]          okind_q, okind_d;
  logic [SEQ_BITS-1:0] oseq_q, oseq_d;
  logic [TAG_BITS-1:0] otag_q, otag_d;
  logic [W-1:0]        obmp_q, obmp_d;
  logic                olast_q, olast_d;

  // memories
  logic [TAG_BITS-1:0] tag_mem [W];
  logic [SEQ_BITS-1:0] mark_mem [W];
  logic [TAG_BITS-1:0] tag_rd_q;
  logic [SEQ_BITS-1:0] mrd_q;

  logic [SEQ_BITS-1:0] off, mo, bdist;
  logic                in_win;
  logic [IDXW:0]       phys_sum;
  logic [IDXW-1:0]     phys, next_head;
  logic [2*SEQ_BITS:0] prod;
  logic [SEQ_BITS-1:0] rfull;
  logic                out_free, tag_we, mark_we, scan_rd;
  cls_e                cls;

  // frame position in the window
  assign off       = seq_q - exp_q;
  assign in_win    = off < SEQ_BITS'(W);
  assign phys_sum  = {1'b0, head_q} + {1'b0, off[IDXW-1:0]};
  assign phys      = (phys_sum >= (IDXW+1)'(W)) ? IDXW'(phys_sum - (IDXW+1)'(W))
                                                : phys_sum[IDXW-1:0];
  assign next_head = (head_q == IDXW'(W - 1)) ? '0 : head_q + 1'b1;
  assign out_free  = !ov_q || !out_stall_i;
  assign mo        = mrd_q - seq_q;
  assign bdist     = mo - min_q;
  assign prod      = {{(SEQ_BITS+1){1'b0}}, seq_q} * {{SEQ_BITS{1'b0}}, RECIP};
  assign rfull     = seq_q - quo_q * SEQ_BITS'(W);
  assign scan_rd   = (cmd_i.scan1 || cmd_i.scan2) && (cnt_q != CNTW'(W));

  always_comb begin
    if (off == '0) cls = CLS_EXP;
    else if (off[SEQ_BITS-1]) cls = CLS_OLD;
    else if (in_win) cls = full_q[phys] ? CLS_DUP : CLS_NEW;
    else cls = CLS_FAR;
  end

  // status to the controller
  always_comb begin
    sts_o.cls       = cls;
    sts_o.req       = mode_q;
    sts_o.req_adv   = (off != '0) && !off[SEQ_BITS-1];
    sts_o.mod_done  = (mcnt_q == '0);
    sts_o.next_full = full_q[next_head];
    sts_o.head_full = full_q[head_q];
    sts_o.steps_one = (steps_q == CNTW'(1));
    sts_o.cnt_end   = (cnt_q == CNTW'(W));
    sts_o.out_free  = out_free;
  end

  // datapath next state
  always_comb begin
    open_d  = open_q;   exp_d   = exp_q;   head_d  = head_q;
    full_d  = full_q;   mvld_d  = mvld_q;
    mode_d  = mode_q;   seq_d   = seq_q;   tag_d   = tag_q;
    quo_d   = quo_q;    mcnt_d  = mcnt_q;  rem_d   = rem_q;
    steps_d = steps_q;  cnt_d   = cnt_q;   pv_d    = pv_q;
    pidx_d  = pidx_q;   min_d   = min_q;   bmp_d   = bmp_q;
    okind_d = okind_q;  oseq_d  = oseq_q;  otag_d  = otag_q;
    obmp_d  = obmp_q;   olast_d = olast_q;
    ov_d    = out_stall_i ? ov_q : 1'b0;
    tag_we  = 1'b0;
    mark_we = 1'b0;

    // take a request
    if (cmd_i.load) begin
      mode_d = mode_i;
      seq_d  = seq_num_i;
      tag_d  = frame_tag_i;
      if (!open_q) begin
        open_d = 1'b1;
        exp_d  = seq_num_i;
      end
      mcnt_d = MODW'(2);
      rem_d  = '0;
    end

    // number mod window: quotient estimate, then one correction
    if (cmd_i.mod_step) begin
      if (mcnt_q == MODW'(2)) begin
        quo_d = SEQ_BITS'(prod >> QSH);
      end else begin
        rem_d = (rfull >= SEQ_BITS'(W)) ? IDXW'(rfull - SEQ_BITS'(W))
                                        : rfull[IDXW-1:0];
      end
      mcnt_d = mcnt_q - 1'b1;
    end

    // data frame decision
    if (cmd_i.data_act) begin
      ov_d    = 1'b1;
      oseq_d  = seq_q;
      otag_d  = tag_q;
      obmp_d  = '0;
      olast_d = 1'b1;
      mark_we = (cls != CLS_FAR);
      if (cls != CLS_FAR) mvld_d[rem_q] = 1'b1;
      case (cls)
        CLS_EXP: begin
          okind_d = KIND_DELIVER;
          olast_d = !full_q[next_head];
          full_d[head_q] = 1'b0;
          head_d  = next_head;
          exp_d   = exp_q + 1'b1;
        end
        CLS_NEW: begin
          okind_d = KIND_BUFFERED;
          full_d[phys] = 1'b1;
          tag_we  = 1'b1;
        end
        CLS_FAR: okind_d = KIND_BEYOND;
        default: okind_d = KIND_OLD;
      endcase
    end

    // deliver a buffered run
    if (cmd_i.drain_emit) begin
      ov_d    = 1'b1;
      okind_d = KIND_DELIVER;
      oseq_d  = exp_q;
      otag_d  = tag_rd_q;
      obmp_d  = '0;
      olast_d = !mode_q && !full_q[next_head];
      full_d[head_q] = 1'b0;
      head_d  = next_head;
      exp_d   = exp_q + 1'b1;
    end

    if (cmd_i.load_steps) begin
      steps_d = in_win ? off[CNTW-1:0] : CNTW'(W);
    end

    // flush below the request number
    if (cmd_i.flush_step) begin
      if (full_q[head_q]) begin
        ov_d    = 1'b1;
        okind_d = KIND_DELIVER;
        oseq_d  = exp_q;
        otag_d  = tag_rd_q;
        obmp_d  = '0;
        olast_d = 1'b0;
      end
      full_d[head_q] = 1'b0;
      head_d  = next_head;
      exp_d   = (steps_q == CNTW'(1)) ? seq_q : exp_q + 1'b1;
      steps_d = steps_q - 1'b1;
    end

    if (cmd_i.scan_init) begin
      cnt_d = '0;
      pv_d  = 1'b0;
      min_d = exp_q - seq_q;
    end

    // purge and oldest mark
    if (cmd_i.scan1 && pv_q && mvld_q[pidx_q]) begin
      if (mo[SEQ_BITS-1]) mvld_d[pidx_q] = 1'b0;
      else if (mo < min_q) min_d = mo;
    end

    // bitmap build
    if (cmd_i.scan2 && pv_q && mvld_q[pidx_q] && (bdist < SEQ_BITS'(W))) begin
      bmp_d[bdist[IDXW-1:0]] = 1'b1;
    end

    // scan address sequence
    if (cmd_i.scan1 || cmd_i.scan2) begin
      pv_d   = scan_rd;
      pidx_d = cnt_q[IDXW-1:0];
      if (scan_rd) cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.scan2_init) begin
      cnt_d = '0;
      pv_d  = 1'b0;
      bmp_d = '0;
    end

    // block-ack report
    if (cmd_i.report) begin
      ov_d    = 1'b1;
      okind_d = KIND_REPORT;
      oseq_d  = seq_q + min_q;
      otag_d  = '0;
      obmp_d  = bmp_q;
      olast_d = 1'b1;
      mvld_d  = '0;
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;  exp_q   <= '0;  head_q  <= '0;
      full_q  <= '0;    mvld_q  <= '0;
      mode_q  <= 1'b0;  seq_q   <= '0;  tag_q   <= '0;
      quo_q   <= '0;    mcnt_q  <= '0;  rem_q   <= '0;
      steps_q <= '0;    cnt_q   <= '0;  pv_q    <= 1'b0;
      pidx_q  <= '0;    min_q   <= '0;  bmp_q   <= '0;
      ov_q    <= 1'b0;  okind_q <= '0;  oseq_q  <= '0;
      otag_q  <= '0;    obmp_q  <= '0;  olast_q <= 1'b0;
    end else begin
      open_q  <= open_d;  exp_q   <= exp_d;   head_q  <= head_d;
      full_q  <= full_d;  mvld_q  <= mvld_d;
      mode_q  <= mode_d;  seq_q   <= seq_d;   tag_q   <= tag_d;
      quo_q   <= quo_d;   mcnt_q  <= mcnt_d;  rem_q   <= rem_d;
      steps_q <= steps_d; cnt_q   <= cnt_d;   pv_q    <= pv_d;
      pidx_q  <= pidx_d;  min_q   <= min_d;   bmp_q   <= bmp_d;
      ov_q    <= ov_d;    okind_q <= okind_d; oseq_q  <= oseq_d;
      otag_q  <= otag_d;  obmp_q  <= obmp_d;  olast_q <= olast_d;
    end
  end

  // slot tag memory
  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[phys] <= tag_q;
    if (cmd_i.tag_rd) tag_rd_q <= tag_mem[head_q];
  end

  // mark memory
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[rem_q] <= seq_q;
    if (scan_rd) mrd_q <= mark_mem[cnt_q[IDXW-1:0]];
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = okind_q;
  assign out_seq_o    = oseq_q;
  assign out_tag_o    = otag_q;
  assign ack_bitmap_o = obmp_q;
  assign last_o       = olast_q;

endmodule

>>> rtl/block_ack_reorder_receiver.sv
// data frame: accepted, then the mark index is found by reciprocal multiplication (a
// quotient estimate, then one correction), then its result, then each buffered frame delivered
// request: the index steps, then a tag read and a step per flushed slot (up to WINDOW), a read
// and emit per run frame, then two passes over the mark memory and one report
// one item at a time; the next item is taken the cycle after its last result is loaded
// reset clears session, slot and mark valid bits at once; no clearing pass
module block_ack_reorder_receiver
  import brr_pkg::*;
#(
  parameter int WINDOW   = 64,
  parameter int SEQ_BITS = 12,
  parameter int TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [SEQ_BITS-1:0] seq_num_i,
  input  logic [TAG_BITS-1:0] frame_tag_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          kind_o,
  output logic [SEQ_BITS-1:0] out_seq_o,
  output logic [TAG_BITS-1:0] out_tag_o,
  output logic [WINDOW-1:0]   ack_bitmap_o,
  output logic                last_o
);

  cmd_t cmd;
  sts_t sts;

  brr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  brr_dp #(
    .W        (WINDOW),
    .SEQ_BITS (SEQ_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_i),
    .seq_num_i    (seq_num_i),
    .frame_tag_i  (frame_tag_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .out_seq_o    (out_seq_o),
    .out_tag_o    (out_tag_o),
    .ack_bitmap_o (ack_bitmap_o),
    .last_o       (last_o)
  );

  // a taken request keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a report carries no tag and ends its request
  a_report_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REPORT |-> out_tag_o == '0 && last_o)
    else $error("malformed report");

  // only reports carry a bitmap
  a_bitmap_only_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_REPORT |-> ack_bitmap_o == '0)
    else $error("bitmap on non-report result");

  // single-result frame outcomes always end their request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BUFFERED || kind_o == KIND_OLD ||
    kind_o == KIND_BEYOND) |-> last_o)
    else $error("frame outcome without last");

endmodule

>>> sim/block_ack_reorder_receiver_tb.sv
`timescale 1ns / 1ps

module block_ack_reorder_receiver_tb
  import brr_pkg::*;
;

  localparam int WINDOW   = 64;
  localparam int SEQ_BITS = 12;
  localparam int TAG_BITS = 16;
  localparam int SEQ_HALF = 1 << (SEQ_BITS - 1);

  typedef struct {
    kind_e                kind;
    logic [SEQ_BITS-1:0]  seq;
    logic [TAG_BITS-1:0]  tag;
    logic [WINDOW-1:0]    bmp;
    logic                 last;
  } rx_result_t;

  // reorder buffer predictor plus queue of pending results
  class reorder_scoreboard;
    bit                   opened;
    logic [SEQ_BITS-1:0]  exp_seq;
    bit                   full_q[WINDOW];
    logic [TAG_BITS-1:0]  tag_q[WINDOW];
    bit                   mark_ok[WINDOW];
    logic [SEQ_BITS-1:0]  mark_seq[WINDOW];
    rx_result_t           pending[$];
    int                   errors;

    function void push_result(kind_e k, logic [SEQ_BITS-1:0] s, logic [TAG_BITS-1:0] t,
                              logic [WINDOW-1:0] b);
      rx_result_t r;
      r.kind = k; r.seq = s; r.tag = t; r.bmp = b; r.last = 1'b0;
      pending.insert(pending.size(), r);
    endfunction

    function void shift_window();
      for (int i = 0; i < WINDOW - 1; i++) begin
        full_q[i] = full_q[i+1];
        tag_q[i]  = tag_q[i+1];
      end
      full_q[WINDOW-1] = 0;
      exp_seq = exp_seq + 1'b1;
    endfunction

    function void deliver_run();
      while (full_q[0]) begin
        push_result(KIND_DELIVER, exp_seq, tag_q[0], '0);
        shift_window();
      end
    endfunction

    function void set_mark(logic [SEQ_BITS-1:0] s);
      mark_ok[s % WINDOW]  = 1;
      mark_seq[s % WINDOW] = s;
    endfunction

    // note one accepted request
    function void note_request(bit mode, logic [SEQ_BITS-1:0] s, logic [TAG_BITS-1:0] t);
      logic [SEQ_BITS-1:0] off, minoff, mo;
      logic [WINDOW-1:0]   bmp;
      int                  steps;
      if (!opened) begin
        opened  = 1;
        exp_seq = s;
      end
      off = s - exp_seq;
      if (!mode) begin
        if (off == 0) begin
          set_mark(s);
          push_result(KIND_DELIVER, s, t, '0);
          shift_window();
          deliver_run();
        end else if (off >= SEQ_HALF) begin
          set_mark(s);
          push_result(KIND_OLD, s, t, '0);
        end else if (off < WINDOW) begin
          set_mark(s);
          if (full_q[off]) begin
            push_result(KIND_OLD, s, t, '0);
          end else begin
            full_q[off] = 1;
            tag_q[off]  = t;
            push_result(KIND_BUFFERED, s, t, '0);
          end
        end else begin
          push_result(KIND_BEYOND, s, t, '0);
        end
      end else begin
        if (off != 0 && off < SEQ_HALF) begin
          steps = (off < WINDOW) ? off : WINDOW;
          for (int i = 0; i < steps; i++) begin
            if (full_q[0]) push_result(KIND_DELIVER, exp_seq, tag_q[0], '0);
            shift_window();
          end
          exp_seq = s;
          deliver_run();
        end
        // drop marks older than the request number
        for (int i = 0; i < WINDOW; i++)
          if (mark_ok[i] && SEQ_BITS'(mark_seq[i] - s) >= SEQ_HALF) mark_ok[i] = 0;
        minoff = exp_seq - s;
        for (int i = 0; i < WINDOW; i++) begin
          mo = mark_seq[i] - s;
          if (mark_ok[i] && mo < minoff) minoff = mo;
        end
        bmp = '0;
        for (int i = 0; i < WINDOW; i++) begin
          mo = mark_seq[i] - s;
          if (mark_ok[i] && (mo - minoff) < WINDOW) bmp[mo - minoff] = 1'b1;
          mark_ok[i] = 0;
        end
        push_result(KIND_REPORT, s + minoff, '0, bmp);
      end
      pending[$].last = 1'b1;
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(rx_result_t got);
      rx_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d seq=%0d", got.kind, got.seq);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.seq !== e.seq) begin
        $error("out_seq: expected %0d actual %0d", e.seq, got.seq); errors++;
      end
      if (got.tag !== e.tag) begin
        $error("out_tag: expected %0h actual %0h", e.tag, got.tag); errors++;
      end
      if (got.bmp !== e.bmp) begin
        $error("ack_bitmap: expected %0h actual %0h", e.bmp, got.bmp); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0b actual %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic                clk_i, rst_ni;
  logic                in_valid_i, in_stall_o, mode_i;
  logic [SEQ_BITS-1:0] seq_num_i;
  logic [TAG_BITS-1:0] frame_tag_i;
  logic                out_valid_o, out_stall_i, last_o;
  logic [2:0]          kind_o;
  logic [SEQ_BITS-1:0] out_seq_o;
  logic [TAG_BITS-1:0] out_tag_o;
  logic [WINDOW-1:0]   ack_bitmap_o;

  reorder_scoreboard sb = new();
  bit                drive_done;
  logic [SEQ_BITS-1:0] base_seq;

  block_ack_reorder_receiver #(
    .WINDOW(WINDOW), .SEQ_BITS(SEQ_BITS), .TAG_BITS(TAG_BITS)
  ) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .seq_num_i, .frame_tag_i,
    .out_valid_o, .out_stall_i, .kind_o, .out_seq_o, .out_tag_o, .ack_bitmap_o, .last_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // valid stays high into the next request when there is no gap
  task automatic send_request(bit mode, logic [SEQ_BITS-1:0] s, logic [TAG_BITS-1:0] t);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    seq_num_i   <= s;
    frame_tag_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(mode, s, t);
  endtask

  // output side: random stall, check at each accepted result
  initial begin
    rx_result_t got;
    int         g;
    out_stall_i = 1'b1;
    wait (rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      if (out_valid_o) begin
        got.kind = kind_e'(kind_o); got.seq = out_seq_o; got.tag = out_tag_o;
        got.bmp  = ack_bitmap_o;    got.last = last_o;
        sb.check_result(got);
      end
    end
  end

  // stimulus
  initial begin
    int r;
    in_valid_i  = 1'b0;
    mode_i      = 1'b0;
    seq_num_i   = '0;
    frame_tag_i = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: open near wrap, in order, buffered, dup, old, beyond, requests
    send_request(1'b0, 12'hFFE, 16'h0000);
    send_request(1'b0, 12'h001, 16'hFFFF);
    send_request(1'b0, 12'h001, 16'hA5A5);
    send_request(1'b0, 12'hFFF, 16'h5A5A);
    send_request(1'b0, 12'h000, 16'h1234);
    send_request(1'b0, 12'hFF0, 16'h0F0F);
    send_request(1'b0, SEQ_BITS'(12'h002 + WINDOW), 16'hF0F0);
    send_request(1'b0, 12'h7FF, 16'h8001);
    send_request(1'b0, 12'h012, 16'h0001);
    send_request(1'b0, SEQ_BITS'(12'h012 + WINDOW), 16'h0002);
    send_request(1'b1, 12'h000, 16'hFFFF);
    send_request(1'b0, 12'h005, 16'h0003);
    send_request(1'b0, 12'h008, 16'h0004);
    send_request(1'b1, 12'h006, 16'h0000);
    for (int i = 0; i < WINDOW; i += 2)
      send_request(1'b0, SEQ_BITS'(12'h00A + i), TAG_BITS'(i));
    send_request(1'b1, 12'h00A + 12'h200, 16'h0000);
    send_request(1'b1, 12'h800, 16'h0000);
    send_request(1'b1, 12'hFFF, 16'h0000);

    // random: mostly near the window, some noise anywhere
    base_seq = sb.exp_seq;
    for (int n = 0; n < 50; n++) begin
      r = $urandom_range(0, 99);
      base_seq = sb.exp_seq;
      if (r < 70)
        send_request(1'b0, SEQ_BITS'(base_seq + $urandom_range(0, WINDOW + 4) - 4),
                     TAG_BITS'($urandom));
      else if (r < 85)
        send_request(1'b1, SEQ_BITS'(base_seq + $urandom_range(0, WINDOW + 8) - 8),
                     TAG_BITS'($urandom));
      else
        send_request(1'($urandom_range(0, 1)), SEQ_BITS'($urandom), TAG_BITS'($urandom));
    end
    in_valid_i <= 1'b0;
    drive_done = 1;
  end

  // end of run
  initial begin
    wait (drive_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
